FILE: src/lpc_pkg.sv
// Shared constants, types and exp tables for the likelihood probability combiner.
`timescale 1ns / 1ps
package lpc_pkg;
  localparam int NUM_DET   = 6;
  localparam int NUM_HYP   = 6;
  localparam int LOGL_W    = 24;
  localparam int IDX_W     = 3;
  localparam int TBL_DEPTH = NUM_DET * NUM_HYP;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int SUM_W     = LOGL_W + 3;
  localparam int DIFF_W    = SUM_W + 1;
  localparam int PRIOR_W   = 10;
  localparam int PRIORS_W  = PRIOR_W * NUM_HYP;
  localparam int EXP_W     = 17;
  localparam int PROD_W    = 2 * EXP_W;
  localparam int WT_W      = 26;
  localparam int NORM_W    = 29;
  localparam int NUM_W     = WT_W + 17;
  localparam int QUO_W     = 17;
  localparam int PROB_W    = 16;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int EXP_INT_LIMIT = 12;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ROWMAX = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR = 1'd1;

  localparam logic [NUM_DET-1:0]  MASK_RESET  = 6'd63;
  localparam logic [PRIORS_W-1:0] PRIOR_RESET = 60'd288512382275027200;

  localparam logic [LOGL_W-1:0] LL_INF_CODE = {1'b0, {(LOGL_W-1){1'b1}}};
  localparam logic [LOGL_W-1:0] LOGL_MIN    = {1'b1, {(LOGL_W-1){1'b0}}};

  typedef logic [LOGL_W-1:0] logl_t;
  typedef logic [EXP_W-1:0]  expv_t;

  function automatic expv_t exp_int(input logic [3:0] q);
    expv_t v;
    case (q)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24109;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic expv_t exp_hi(input logic [3:0] i);
    expv_t v;
    case (i)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  function automatic expv_t exp_lo(input logic [3:0] i);
    expv_t v;
    case (i)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63026;
      4'd11: v = 17'd62781;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction
endpackage

FILE: src/lpc_table.sv
// Log-likelihood table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module lpc_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [lpc_pkg::ADDR_W-1:0] waddr,
  input  lpc_pkg::logl_t            wdata,
  input  logic [lpc_pkg::ADDR_W-1:0] raddr,
  output lpc_pkg::logl_t            rdata
);
  import lpc_pkg::*;

  logl_t mem [TBL_DEPTH];
  logl_t rdata_r;
  logic [ADDR_W-1:0] clr_r;
  logic clr_busy_r;

  // After reset, sweep zeros through the table before first use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      mem[clr_r] <= '0;
      if (clr_r == ADDR_W'(TBL_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: src/lpc_mul.sv
// Shared 17x17 multiplier with registered product.
`timescale 1ns / 1ps
module lpc_mul (
  input  logic                       clk,
  input  lpc_pkg::expv_t             a,
  input  lpc_pkg::expv_t             b,
  output logic [lpc_pkg::PROD_W-1:0] prod
);
  import lpc_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;
endmodule

FILE: src/lpc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lpc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpc_pkg::NUM_W-1:0]  num,
  input  logic [lpc_pkg::NORM_W-1:0] den,
  output logic                       done,
  output logic [lpc_pkg::QUO_W-1:0]  quo
);
  import lpc_pkg::*;

  logic [NORM_W-1:0] rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  quo_r;
  logic [4:0]        cnt_r;
  logic              run_r;
  logic              done_r;
  logic [NORM_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= NORM_W'(num[NUM_W-1:QUO_W]);
        low_r <= num[QUO_W-1:0];
        quo_r <= '0;
        cnt_r <= 5'(QUO_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? NORM_W'(trial - {1'b0, den}) : NORM_W'(trial);
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

FILE: src/likelihood_probability_combiner.sv
// Top level: table, sequencer, shared multiplier and divider.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | opcode, detector, hypothesis, log_likelihood
//  out     | out_valid / out_ready  | hypothesis_out, probability, most_likely, ...
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A write gives one beat. Row maxima make two passes over each row, with one
// table read per entry in each pass. A query's run is set by the single table
// read port and the serial divider, and it waits on output stalls. After reset
// the table is zeroed while in_ready stays low; cfg_ready is always high.
`timescale 1ns / 1ps
module likelihood_probability_combiner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpc_pkg::OP_W-1:0]      in_opcode,
  input  logic [lpc_pkg::IDX_W-1:0]     in_detector,
  input  logic [lpc_pkg::IDX_W-1:0]     in_hypothesis,
  input  logic signed [lpc_pkg::LOGL_W-1:0] in_log_likelihood,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpc_pkg::IDX_W-1:0]     out_hypothesis_out,
  output logic [lpc_pkg::PROB_W-1:0]    out_probability,
  output logic [lpc_pkg::IDX_W-1:0]     out_most_likely,
  output logic                          out_any_present,
  output logic                          out_error,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpc_pkg::PRIORS_W-1:0]  cfg_data
);
  import lpc_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RM_A   = 4'd2;
  localparam logic [3:0] S_RM_B   = 4'd3;
  localparam logic [3:0] S_RS_A   = 4'd4;
  localparam logic [3:0] S_RS_B   = 4'd5;
  localparam logic [3:0] S_QS_A   = 4'd6;
  localparam logic [3:0] S_QS_B   = 4'd7;
  localparam logic [3:0] S_QE1    = 4'd8;
  localparam logic [3:0] S_QE2    = 4'd9;
  localparam logic [3:0] S_QE3    = 4'd10;
  localparam logic [3:0] S_QACC   = 4'd11;
  localparam logic [3:0] S_QDIV   = 4'd12;
  localparam logic [3:0] S_QWAIT  = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  localparam logic [IDX_W-1:0] LAST_D = IDX_W'(NUM_DET - 1);
  localparam logic [IDX_W-1:0] LAST_H = IDX_W'(NUM_HYP - 1);

  logic [3:0]          state_r;
  logic [5:0]          init_cnt_r;
  logic [IDX_W-1:0]    d_r, h_r;
  logic [NUM_DET-1:0]  mask_r, present_r;
  logic [PRIORS_W-1:0] priors_r;
  logl_t               m_r;
  logic [SUM_W-1:0]    acc_r, best_r;
  logic                have_r;
  logic [SUM_W-1:0]    sum_r [NUM_HYP];
  logic [WT_W-1:0]     wt_r [NUM_HYP];
  logic [PROB_W-1:0]   prob_r [NUM_HYP];
  logic [NORM_W-1:0]   norm_r;
  logic [PROB_W-1:0]   top_r;
  logic [IDX_W-1:0]    most_r;
  logic [3:0]          nlo_r;
  logic                kill_r;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_hyp_r, out_most_r;
  logic [PROB_W-1:0]   out_prob_r;
  logic                out_any_r, out_err_r, out_last_r;

  logic                tbl_we;
  logic [ADDR_W-1:0]   tbl_waddr, tbl_raddr, cnt_addr;
  logl_t               tbl_wdata, tbl_rdata;
  expv_t               mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  expv_t               fx;
  logic                div_start, div_done;
  logic [QUO_W-1:0]    quo;
  logic [NUM_W-1:0]    div_num;

  logic                slot_free, in_acc, is_inf, in_range, do_write, out_load;
  logic [NUM_DET-1:0]  present_new;
  logic [LOGL_W:0]     rs_diff;
  logl_t               rs_val;
  logic [SUM_W-1:0]    acc_new;
  logic [DIFF_W-1:0]   ndiff;
  logic [PRIOR_W-1:0]  prior_h;
  logic [PROB_W-1:0]   p_div;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign is_inf   = in_log_likelihood == LL_INF_CODE;
  assign in_range = (in_detector < IDX_W'(NUM_DET)) && (in_hypothesis < IDX_W'(NUM_HYP));
  assign do_write = in_acc && (in_opcode == OP_WRITE) && !is_inf && in_range;
  assign present_new = do_write ? (present_r | (NUM_DET'(1) << in_detector)) : present_r;
  // A new beat is loaded into the output register this cycle.
  assign out_load = (in_acc && (in_opcode == OP_WRITE)) || ((state_r == S_EMIT) && slot_free);

  assign cnt_addr = ADDR_W'(d_r) * ADDR_W'(NUM_HYP) + ADDR_W'(h_r);

  assign rs_diff = {tbl_rdata[LOGL_W-1], tbl_rdata} - {m_r[LOGL_W-1], m_r};
  // Clamp at the signed minimum when the difference leaves the range.
  assign rs_val  = (rs_diff[LOGL_W] != rs_diff[LOGL_W-1]) ? LOGL_MIN : rs_diff[LOGL_W-1:0];

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cnt_addr;
    tbl_wdata = rs_val;
    if (do_write) begin
      tbl_we    = 1'b1;
      tbl_waddr = ADDR_W'(in_detector) * ADDR_W'(NUM_HYP) + ADDR_W'(in_hypothesis);
      tbl_wdata = in_log_likelihood;
    end else if (state_r == S_RS_B) begin
      tbl_we = 1'b1;
    end
  end
  assign tbl_raddr = cnt_addr;

  lpc_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign acc_new = acc_r + (mask_r[d_r] ? {{(SUM_W-LOGL_W){tbl_rdata[LOGL_W-1]}}, tbl_rdata}
                                        : SUM_W'(0));
  assign ndiff   = {best_r[SUM_W-1], best_r} - {sum_r[h_r][SUM_W-1], sum_r[h_r]};
  assign prior_h = priors_r[PRIOR_W*h_r +: PRIOR_W];

  // Round the Q2.32 product of two Q1.16 values back to Q1.16.
  assign fx = prod[32:16] + EXP_W'(prod[15]);

  always_comb begin
    unique case (state_r)
      S_QE1: begin
        mul_a = exp_int(ndiff[11:8]);
        mul_b = exp_hi(ndiff[7:4]);
      end
      S_QE2: begin
        mul_a = fx;
        mul_b = exp_lo(nlo_r);
      end
      default: begin
        mul_a = fx;
        mul_b = EXP_W'(prior_h);
      end
    endcase
  end

  lpc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_start = (state_r == S_QDIV) && (norm_r != '0);
  assign div_num   = {wt_r[h_r], 16'd0} + NUM_W'(norm_r >> 1);

  lpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (norm_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign p_div = quo[QUO_W-1] ? {PROB_W{1'b1}} : quo[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      d_r         <= '0;
      h_r         <= '0;
      mask_r      <= MASK_RESET;
      priors_r    <= PRIOR_RESET;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MASK) begin
          mask_r <= cfg_data[NUM_DET-1:0];
        end else begin
          priors_r <= cfg_data;
        end
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      present_r <= present_new;

      unique case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == 6'(TBL_DEPTH)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          d_r <= '0;
          h_r <= '0;
          if (in_acc) begin
            unique case (in_opcode)
              OP_WRITE: begin
                out_valid_r <= 1'b1;
                out_hyp_r   <= in_hypothesis;
                out_prob_r  <= '0;
                out_most_r  <= '0;
                out_any_r   <= |(present_new & mask_r);
                out_err_r   <= is_inf;
                out_last_r  <= 1'b1;
              end
              OP_ROWMAX: state_r <= S_RM_A;
              OP_QUERY: begin
                state_r <= S_QS_A;
                acc_r   <= '0;
                have_r  <= 1'b0;
                norm_r  <= '0;
                top_r   <= '0;
                most_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RM_A: state_r <= S_RM_B;
        S_RM_B: begin
          if ((h_r == '0) || ($signed(tbl_rdata) > $signed(m_r))) begin
            m_r <= tbl_rdata;
          end
          if (h_r == LAST_H) begin
            h_r     <= '0;
            state_r <= S_RS_A;
          end else begin
            h_r     <= h_r + 1'b1;
            state_r <= S_RM_A;
          end
        end
        S_RS_A: state_r <= S_RS_B;
        S_RS_B: begin
          if (h_r == LAST_H) begin
            h_r <= '0;
            if (d_r == LAST_D) begin
              state_r <= S_IDLE;
            end else begin
              d_r     <= d_r + 1'b1;
              state_r <= S_RM_A;
            end
          end else begin
            h_r     <= h_r + 1'b1;
            state_r <= S_RS_A;
          end
        end
        S_QS_A: state_r <= S_QS_B;
        S_QS_B: begin
          if (d_r == LAST_D) begin
            d_r        <= '0;
            acc_r      <= '0;
            sum_r[h_r] <= acc_new;
            if ((prior_h != '0) && (!have_r || ($signed(acc_new) > $signed(best_r)))) begin
              best_r <= acc_new;
              have_r <= 1'b1;
            end
            if (h_r == LAST_H) begin
              h_r     <= '0;
              state_r <= S_QE1;
            end else begin
              h_r     <= h_r + 1'b1;
              state_r <= S_QS_A;
            end
          end else begin
            acc_r   <= acc_new;
            d_r     <= d_r + 1'b1;
            state_r <= S_QS_A;
          end
        end
        S_QE1: begin
          nlo_r   <= ndiff[3:0];
          kill_r  <= !have_r || (prior_h == '0) ||
                     (ndiff[DIFF_W-1:8] >= (DIFF_W-8)'(EXP_INT_LIMIT));
          state_r <= S_QE2;
        end
        S_QE2: state_r <= S_QE3;
        S_QE3: state_r <= S_QACC;
        S_QACC: begin
          wt_r[h_r] <= kill_r ? WT_W'(0) : prod[WT_W-1:0];
          norm_r    <= norm_r + (kill_r ? NORM_W'(0) : NORM_W'(prod[WT_W-1:0]));
          if (h_r == LAST_H) begin
            h_r     <= '0;
            state_r <= S_QDIV;
          end else begin
            h_r     <= h_r + 1'b1;
            state_r <= S_QE1;
          end
        end
        S_QDIV: begin
          if (norm_r == '0) begin
            prob_r[h_r] <= '0;
            if (h_r == LAST_H) begin
              h_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              h_r <= h_r + 1'b1;
            end
          end else begin
            state_r <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          if (div_done) begin
            prob_r[h_r] <= p_div;
            if (p_div > top_r) begin
              top_r  <= p_div;
              most_r <= h_r;
            end
            if (h_r == LAST_H) begin
              h_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              h_r     <= h_r + 1'b1;
              state_r <= S_QDIV;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_hyp_r   <= h_r;
            out_prob_r  <= prob_r[h_r];
            out_most_r  <= most_r;
            out_any_r   <= |(present_r & mask_r);
            out_err_r   <= 1'b0;
            out_last_r  <= h_r == LAST_H;
            if (h_r == LAST_H) begin
              state_r <= S_IDLE;
            end else begin
              h_r <= h_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hypothesis_out = out_hyp_r;
  assign out_probability    = out_prob_r;
  assign out_most_likely    = out_most_r;
  assign out_any_present    = out_any_r;
  assign out_error          = out_err_r;
  assign out_last           = out_last_r;
endmodule

FILE: dv/tb_likelihood_probability_combiner.sv
// Self-checking testbench for the likelihood probability combiner.
`timescale 1ns / 1ps
module tb_likelihood_probability_combiner;
  import lpc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  hyp;
    logic [PROB_W-1:0] prob;
    logic [IDX_W-1:0]  most;
    logic              anyp;
    logic              err;
    logic              last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_opcode = '0;
  logic [IDX_W-1:0] in_detector = '0;
  logic [IDX_W-1:0] in_hypothesis = '0;
  logic signed [LOGL_W-1:0] in_log_likelihood = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_hypothesis_out;
  logic [PROB_W-1:0] out_probability;
  logic [IDX_W-1:0] out_most_likely;
  logic out_any_present, out_error, out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PRIORS_W-1:0] cfg_data = '0;

  likelihood_probability_combiner u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [LOGL_W-1:0] ll_tbl [NUM_DET][NUM_HYP];
  logic [NUM_DET-1:0]  present_bits;
  logic [NUM_DET-1:0]  det_mask;
  logic [PRIORS_W-1:0] priors;

  beat_t expected_beats[$];
  int    n_errors = 0;
  bit    allow_idle = 1'b1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [16:0] fx_mul(input logic [16:0] a, input logic [16:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'd32768;
    return 17'(p >> 16);
  endfunction

  function automatic logic [16:0] exp_neg(input longint unsigned n);
    logic [16:0] a, v;
    longint unsigned q;
    q = n >> 8;
    if (q >= 12) return 17'd0;
    case (q)
      0: a = 65536; 1: a = 24109; 2: a = 8869; 3: a = 3263; 4: a = 1200; 5: a = 442;
      6: a = 162; 7: a = 60; 8: a = 22; 9: a = 8; 10: a = 3; default: a = 1;
    endcase
    case ((n >> 4) & 15)
      0: v = 65536; 1: v = 61565; 2: v = 57835; 3: v = 54331; 4: v = 51039;
      5: v = 47947; 6: v = 45042; 7: v = 42313; 8: v = 39750; 9: v = 37341;
      10: v = 35079; 11: v = 32954; 12: v = 30957; 13: v = 29081; 14: v = 27319;
      default: v = 25664;
    endcase
    v = fx_mul(a, v);
    case (n & 15)
      0: a = 65536; 1: a = 65280; 2: a = 65026; 3: a = 64772; 4: a = 64520;
      5: a = 64268; 6: a = 64018; 7: a = 63768; 8: a = 63520; 9: a = 63272;
      10: a = 63026; 11: a = 62781; 12: a = 62535; 13: a = 62291; 14: a = 62048;
      default: a = 61806;
    endcase
    return fx_mul(v, a);
  endfunction

  task automatic predict_combiner(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] det,
                                  input logic [IDX_W-1:0] hyp, input logic signed [LOGL_W-1:0] ll);
    beat_t b;
    longint s [NUM_HYP];
    longint unsigned wt [NUM_HYP];
    longint unsigned pr [NUM_HYP];
    longint m, r, best_sum;
    longint unsigned norm, top, p, pw;
    int most;
    bit have;
    if (op == OP_WRITE) begin
      if (ll != LL_INF_CODE && det < NUM_DET && hyp < NUM_HYP) begin
        ll_tbl[det][hyp] = ll;
        present_bits[det] = 1'b1;
      end
      b = '{hyp: hyp, prob: '0, most: '0, anyp: |(present_bits & det_mask),
            err: (ll == LL_INF_CODE), last: 1'b1};
      expected_beats.insert(expected_beats.size(), b);
    end else if (op == OP_ROWMAX) begin
      for (int d = 0; d < NUM_DET; d++) begin
        m = ll_tbl[d][0];
        for (int h = 1; h < NUM_HYP; h++) if (ll_tbl[d][h] > m) m = ll_tbl[d][h];
        for (int h = 0; h < NUM_HYP; h++) begin
          r = longint'(ll_tbl[d][h]) - m;
          if (r < -(64'sd1 << (LOGL_W-1))) r = -(64'sd1 << (LOGL_W-1));
          ll_tbl[d][h] = LOGL_W'(r);
        end
      end
    end else if (op == OP_QUERY) begin
      have = 0; best_sum = 0; norm = 0; top = 0; most = 0;
      for (int h = 0; h < NUM_HYP; h++) begin
        s[h] = 0;
        for (int d = 0; d < NUM_DET; d++) if (det_mask[d]) s[h] += ll_tbl[d][h];
        if (priors[PRIOR_W*h +: PRIOR_W] != 0 && (!have || s[h] > best_sum)) begin
          best_sum = s[h];
          have = 1;
        end
      end
      for (int h = 0; h < NUM_HYP; h++) begin
        pw = priors[PRIOR_W*h +: PRIOR_W];
        wt[h] = (pw != 0) ? pw * exp_neg(best_sum - s[h]) : 0;
        norm += wt[h];
      end
      for (int h = 0; h < NUM_HYP; h++) begin
        p = 0;
        if (norm != 0) begin
          p = (wt[h] * 65536 + norm / 2) / norm;
          if (p > 65535) p = 65535;
        end
        pr[h] = p;
        if (p > top) begin
          top = p;
          most = h;
        end
      end
      for (int h = 0; h < NUM_HYP; h++) begin
        b = '{hyp: h, prob: pr[h], most: most, anyp: |(present_bits & det_mask),
              err: 1'b0, last: (h == NUM_HYP-1)};
        expected_beats.insert(expected_beats.size(), b);
      end
    end
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    beat_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_hypothesis_out, 0);
      end else begin
        w = expected_beats.pop_front();
        if (out_hypothesis_out !== w.hyp) report("hypothesis_out", out_hypothesis_out, w.hyp);
        if (out_probability !== w.prob) report("probability", out_probability, w.prob);
        if (out_most_likely !== w.most) report("most_likely", out_most_likely, w.most);
        if (out_any_present !== w.anyp) report("any_present", out_any_present, w.anyp);
        if (out_error !== w.err) report("error", out_error, w.err);
        if (out_last !== w.last) report("last", out_last, w.last);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!allow_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Valid stays up across back-to-back beats; drop it only before an idle gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] det,
                           input logic [IDX_W-1:0] hyp, input logic signed [LOGL_W-1:0] ll);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_detector <= det;
    in_hypothesis <= hyp;
    in_log_likelihood <= ll;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_combiner(op, det, hyp, ll);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    // rowmax gives no beat and may still be running
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRIORS_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MASK) det_mask = val[NUM_DET-1:0];
    else priors = val;
  endtask

  function automatic logic signed [LOGL_W-1:0] rand_ll();
    case ($urandom_range(0, 5))
      0: return LL_INF_CODE;
      1: return LOGL_MIN;
      2: return LOGL_W'($urandom);
      default: return LOGL_W'($signed($urandom_range(0, 8192)) - 6144);
    endcase
  endfunction

  task automatic test_directed;
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_WRITE, 0, 0, LL_INF_CODE);
    send_item(OP_WRITE, 7, 0, 24'sd100);
    send_item(OP_WRITE, 0, 7, 24'sd100);
    send_item(OP_WRITE, 0, 0, LOGL_MIN);
    send_item(OP_WRITE, 0, 1, LL_INF_CODE - 1);
    send_item(OP_WRITE, 5, 5, 24'sd512);
    send_item(OP_WRITE, 3, 2, -24'sd256);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_ROWMAX, 0, 0, 0);
    send_item(OP_UNUSED, 7, 7, -24'sd1);
    send_item(OP_QUERY, 7, 7, 0);
    send_item(OP_WRITE, 4, 4, 24'sd3000);
    send_item(OP_WRITE, 4, 3, 24'sd0);
    send_item(OP_QUERY, 0, 0, 0);
  endtask

  task automatic test_config_extremes;
    write_reg(CFG_PRIOR, '0);
    send_item(OP_QUERY, 0, 0, 0);
    write_reg(CFG_MASK, '0);
    write_reg(CFG_PRIOR, '1);
    send_item(OP_WRITE, 1, 1, 24'sd77);
    send_item(OP_QUERY, 0, 0, 0);
    write_reg(CFG_MASK, 6'd63);
    write_reg(CFG_PRIOR, {10'd0, 10'd1023, 10'd0, 10'd1, 10'd0, 10'd256});
    send_item(OP_QUERY, 0, 0, 0);
  endtask

  task automatic test_random(input int n_items);
    logic [OP_W-1:0] op;
    for (int i = 0; i < n_items; i++) begin
      if (i % 125 == 0 && i != 0) begin
        write_reg(CFG_MASK, $urandom_range(0, 63));
        write_reg(CFG_PRIOR, PRIORS_W'({$urandom, $urandom}));
      end
      case ($urandom_range(0, 15))
        0:        op = OP_ROWMAX;
        1:        op = OP_UNUSED;
        2, 3, 4:  op = OP_QUERY;
        default:  op = OP_WRITE;
      endcase
      send_item(op, ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5),
                ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5),
                rand_ll());
    end
  endtask

  initial begin
    for (int d = 0; d < NUM_DET; d++)
      for (int h = 0; h < NUM_HYP; h++) ll_tbl[d][h] = '0;
    present_bits = '0;
    det_mask = MASK_RESET;
    priors = PRIOR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    write_reg(CFG_PRIOR, PRIOR_RESET);
    test_random(400);
    drain();
    allow_idle = 1'b0;
    test_random(100);
    drain();
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
